// ===== design/dhc_pkg.sv =====
// ----------------------------------------------------------------------------
// dhc_pkg: shared definitions for the depth histogram colouriser
// Command codes, register indexes, channel payload types, sequencer states
// and the colour weight table.
// ----------------------------------------------------------------------------
package dhc_pkg;

	// Configuration port
	localparam int CFG_DATA_W  = 10;
	localparam int CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH     = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DRAW_PIXELS     = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_DRAW_BACKGROUND = 2'd3;

	// Commands
	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_FINISH = 2'd1;
	localparam logic [1:0] CMD_DRAIN  = 2'd2;

	// Fixed widths
	localparam int COLOUR_W = 8;
	localparam int QUO_W    = 9;   // brightness 0..256
	localparam int CI_W     = 4;   // colour index 0..10

	localparam logic [CI_W-1:0] WHITE_INDEX = 4'd10;

	// Channel weights
	typedef logic [1:0] weight_t;
	localparam weight_t W_NONE = 2'd0;
	localparam weight_t W_HALF = 2'd1;
	localparam weight_t W_FULL = 2'd2;

	localparam weight_t WEIGHT_TABLE [11][3] = '{
		'{W_NONE, W_FULL, W_FULL},
		'{W_NONE, W_NONE, W_FULL},
		'{W_NONE, W_FULL, W_NONE},
		'{W_FULL, W_FULL, W_NONE},
		'{W_FULL, W_NONE, W_NONE},
		'{W_FULL, W_HALF, W_NONE},
		'{W_HALF, W_FULL, W_NONE},
		'{W_NONE, W_HALF, W_FULL},
		'{W_HALF, W_NONE, W_FULL},
		'{W_FULL, W_FULL, W_HALF},
		'{W_FULL, W_FULL, W_FULL}
	};

	// Channel payloads
	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] depth;
		logic [7:0]  label;
	} in_item_t;

	typedef struct packed {
		logic [COLOUR_W-1:0] first_channel;
		logic [COLOUR_W-1:0] second_channel;
		logic [COLOUR_W-1:0] third_channel;
		logic                last_pixel;
		logic                out_of_order;
	} out_item_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_LOAD_INC,
		ST_FIN_RD,
		ST_FIN_ACC,
		ST_FIN_CHK,
		ST_FIN_DIV,
		ST_FIN_WR,
		ST_DRN_RD,
		ST_DRN_LV,
		ST_DRN_COL,
		ST_OUT
	} state_t;

	// Apply a channel weight; brightness 256 wraps to 0 at full weight
	function automatic logic [COLOUR_W-1:0] weigh(input logic [QUO_W-1:0] v,
			input weight_t code);
		logic [COLOUR_W-1:0] r;
		case (code)
			W_FULL: r = v[COLOUR_W-1:0];
			W_HALF: r = v[QUO_W-1:1];
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== design/dhc_stream_if.sv =====
// ----------------------------------------------------------------------------
// dhc_stream_if: valid/ready channel
// Carries one payload per transaction, accepted when valid and ready are high.
// ----------------------------------------------------------------------------
interface dhc_stream_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/depth_histogram_colorizer.sv =====
// ----------------------------------------------------------------------------
// depth_histogram_colorizer: histogram-equalised depth to RGB colouriser
// Loads a frame of depth/label pixels, builds a brightness table from the
// depth histogram and drains one coloured pixel per drain command.
// ----------------------------------------------------------------------------
// Usage:
//   pix_in carries commands (load, finish, drain) with depth and label.
//   pix_out carries one colour transaction per drain command.
//   cfg_we/cfg_index/cfg_data write frame size and draw modes while idle.
// States from acceptance until the next command can be taken: load uses
// ST_LOAD, then ST_LOAD_INC (histogram read-modify-write) unless ignored
// or of zero depth; drain uses ST_OUT out of phase, or in phase ST_DRN_RD,
// ST_DRN_LV and ST_DRN_COL as needed, then ST_OUT, plus any wait for
// pix_out; finish walks DEPTH_LEVELS levels through a single shared
// compare/subtract divider, each level in ST_FIN_RD, ST_FIN_ACC, ST_FIN_CHK,
// ST_FIN_DIV (the 9-step restoring division) and ST_FIN_WR; level 0, any
// level of a frame with no nonzero depth and an empty level above level 1
// skip ST_FIN_DIV. The histogram memory has one read and one write port;
// each sequencer step uses it at most once. Reset and the final drain of
// a frame clear all DEPTH_LEVELS histogram levels; pix_in is not ready then.
// A stalled receiver holds the result in the output register; only a
// drain that finds it still full waits.
// ----------------------------------------------------------------------------
module depth_histogram_colorizer
	import dhc_pkg::*;
#(
	parameter int MAX_WIDTH    = 640,
	parameter int MAX_HEIGHT   = 480,
	parameter int DEPTH_LEVELS = 16384,
	parameter int COLOR_COUNT  = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	dhc_stream_if.sink             pix_in,
	dhc_stream_if.source           pix_out
);

	localparam int PIXELS    = MAX_WIDTH * MAX_HEIGHT;
	localparam int PIX_W     = $clog2(PIXELS + 1);
	localparam int PADDR_W   = $clog2(PIXELS);
	localparam int LEVEL_W   = $clog2(DEPTH_LEVELS);
	localparam int CNT_W     = PIX_W;
	localparam int WW        = $clog2(MAX_WIDTH + 1);
	localparam int HW        = $clog2(MAX_HEIGHT + 1);
	localparam int WX        = (WW > 10) ? WW : 10;
	localparam int HX        = (HW > 9) ? HW : 9;
	localparam int PIX_DW    = CI_W + LEVEL_W;
	localparam int DIVC_W    = $clog2(QUO_W);

	localparam logic [LEVEL_W-1:0] LAST_LEVEL = LEVEL_W'(DEPTH_LEVELS - 1);

	// Registers
	state_t               state_q, state_d;
	logic                 phase_drain_q;
	logic [9:0]           cfg_width_q;
	logic [8:0]           cfg_height_q;
	logic                 cfg_draw_pixels_q;
	logic                 cfg_draw_bg_q;
	logic [PIX_W-1:0]     loaded_q;
	logic [CNT_W-1:0]     nonzero_q;
	logic [PIX_W-1:0]     pos_q;
	logic [LEVEL_W-1:0]   lvl_q;
	logic [DIVC_W-1:0]    div_cnt_q;
	logic                 out_valid_q;
	out_item_t            out_data_q;
	out_item_t            res_q;
	logic [PIX_W-1:0]     total_q;
	logic [CNT_W-1:0]     cdf_q;
	logic [QUO_W-1:0]     prev_q;
	logic [QUO_W-1:0]     fin_val_q;
	logic [CNT_W:0]       rem_q;
	logic [LEVEL_W-1:0]   ld_lv_q;
	logic [CI_W-1:0]      ld_ci_q;
	logic [CI_W-1:0]      ci_q;
	logic [CNT_W-1:0]     hist_rd_q;
	logic [PIX_DW-1:0]    pix_rd_q;

	// Memories
	logic [CNT_W-1:0]     hist_mem [DEPTH_LEVELS];
	logic [PIX_DW-1:0]    pix_mem [PIXELS];

	// Memory controls
	logic                 hist_re, hist_we;
	logic [LEVEL_W-1:0]   hist_raddr, hist_waddr;
	logic [CNT_W-1:0]     hist_wdata;
	logic                 pix_re, pix_we;

	// Misc combinational
	logic                 accept, push;
	logic [CI_W-1:0]      mod_lut [256];
	logic [LEVEL_W-1:0]   in_lv;
	logic [CI_W-1:0]      in_ci;
	logic [WX-1:0]        fw_x;
	logic [HX-1:0]        fh_x;
	logic [WW-1:0]        w_eff;
	logic [HW-1:0]        h_eff;
	logic                 load_ok;
	logic                 fin_zero, fin_reuse;
	logic [CNT_W:0]       div_t;
	logic                 div_ge;
	logic [PIX_W:0]       pos_inc;
	logic                 render;
	logic [CI_W-1:0]      px_ci_raw, px_ci;
	logic [LEVEL_W-1:0]   px_lv;
	logic                 px_colour;

	// Label modulo colour count as a constant table
	for (genvar g = 0; g < 256; g++) begin : g_mod_lut
		assign mod_lut[g] = CI_W'(g % COLOR_COUNT);
	end

	// Handshakes
	assign pix_in.ready  = (state_q == ST_IDLE);
	assign accept        = pix_in.valid && pix_in.ready;
	assign pix_out.valid = out_valid_q;
	assign pix_out.data  = out_data_q;
	assign push          = (state_q == ST_OUT) && (!out_valid_q || pix_out.ready);

	// Depth clamp and colour index of the incoming pixel
	assign in_lv = ({1'b0, pix_in.data.depth} > 17'(DEPTH_LEVELS - 1)) ? LAST_LEVEL
		: LEVEL_W'(pix_in.data.depth);
	assign in_ci = (pix_in.data.label == 8'd0) ? WHITE_INDEX : mod_lut[pix_in.data.label];

	// Effective frame size
	assign fw_x  = WX'(cfg_width_q);
	assign fh_x  = HX'(cfg_height_q);
	assign w_eff = (fw_x == '0) ? WW'(1) : (fw_x > WX'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(fw_x);
	assign h_eff = (fh_x == '0) ? HW'(1) : (fh_x > HX'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT)
		: HW'(fh_x);

	// Sequencer conditions
	assign load_ok   = !phase_drain_q && (loaded_q < total_q);
	assign fin_zero  = (lvl_q == '0) || (nonzero_q == '0) || (cdf_q > nonzero_q);
	assign fin_reuse = (hist_rd_q == '0) && (lvl_q > LEVEL_W'(1));
	assign div_t     = (div_cnt_q == '0) ? rem_q : {rem_q[CNT_W-1:0], 1'b0};
	assign div_ge    = div_t >= {1'b0, nonzero_q};
	assign pos_inc   = {1'b0, pos_q} + 1'b1;
	assign render    = cfg_draw_pixels_q && (pos_q < loaded_q);
	assign px_ci_raw = pix_rd_q[PIX_DW-1 -: CI_W];
	assign px_ci     = (px_ci_raw > WHITE_INDEX) ? WHITE_INDEX : px_ci_raw;
	assign px_lv     = pix_rd_q[LEVEL_W-1:0];
	assign px_colour = (cfg_draw_bg_q || px_ci != WHITE_INDEX) && (px_lv != '0);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (lvl_q == LAST_LEVEL) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					case (pix_in.data.cmd)
						CMD_LOAD: state_d = ST_LOAD;
						CMD_FINISH: state_d = phase_drain_q ? ST_IDLE : ST_FIN_RD;
						CMD_DRAIN: state_d = phase_drain_q ? ST_DRN_RD : ST_OUT;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_LOAD: begin
				state_d = (load_ok && ld_lv_q != '0) ? ST_LOAD_INC : ST_IDLE;
			end
			ST_LOAD_INC: state_d = ST_IDLE;
			ST_FIN_RD: state_d = ST_FIN_ACC;
			ST_FIN_ACC: state_d = ST_FIN_CHK;
			ST_FIN_CHK: begin
				state_d = (fin_zero || fin_reuse) ? ST_FIN_WR : ST_FIN_DIV;
			end
			ST_FIN_DIV: begin
				if (div_cnt_q == DIVC_W'(QUO_W - 1)) state_d = ST_FIN_WR;
			end
			ST_FIN_WR: begin
				state_d = (lvl_q == LAST_LEVEL) ? ST_IDLE : ST_FIN_RD;
			end
			ST_DRN_RD: state_d = render ? ST_DRN_LV : ST_OUT;
			ST_DRN_LV: state_d = px_colour ? ST_DRN_COL : ST_OUT;
			ST_DRN_COL: state_d = ST_OUT;
			ST_OUT: begin
				if (push) state_d = res_q.last_pixel ? ST_CLEAR : ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory controls per state
	always_comb begin
		hist_re    = 1'b0;
		hist_raddr = lvl_q;
		hist_we    = 1'b0;
		hist_waddr = lvl_q;
		hist_wdata = '0;
		pix_re     = 1'b0;
		pix_we     = 1'b0;
		case (state_q)
			ST_CLEAR: hist_we = 1'b1;
			ST_LOAD: begin
				pix_we     = load_ok;
				hist_re    = 1'b1;
				hist_raddr = ld_lv_q;
			end
			ST_LOAD_INC: begin
				hist_we    = 1'b1;
				hist_waddr = ld_lv_q;
				hist_wdata = hist_rd_q + 1'b1;
			end
			ST_FIN_RD: hist_re = 1'b1;
			ST_FIN_WR: begin
				hist_we    = 1'b1;
				hist_wdata = CNT_W'(fin_val_q);
			end
			ST_DRN_RD: pix_re = 1'b1;
			ST_DRN_LV: begin
				hist_re    = px_colour;
				hist_raddr = px_lv;
			end
			default: ;
		endcase
	end

	// Histogram memory
	always_ff @(posedge clk) begin
		if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
		if (hist_re) hist_rd_q <= hist_mem[hist_raddr];
	end

	// Pixel memory: colour index over clamped depth
	always_ff @(posedge clk) begin
		if (pix_we) pix_mem[loaded_q[PADDR_W-1:0]] <= {ld_ci_q, ld_lv_q};
		if (pix_re) pix_rd_q <= pix_mem[pos_q[PADDR_W-1:0]];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_CLEAR;
			phase_drain_q     <= 1'b0;
			cfg_width_q       <= 10'd640;
			cfg_height_q      <= 9'd480;
			cfg_draw_pixels_q <= 1'b1;
			cfg_draw_bg_q     <= 1'b1;
			loaded_q          <= '0;
			nonzero_q         <= '0;
			pos_q             <= '0;
			lvl_q             <= '0;
			div_cnt_q         <= '0;
			out_valid_q       <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				case (cfg_index)
					REG_FRAME_WIDTH: cfg_width_q <= cfg_data;
					REG_FRAME_HEIGHT: cfg_height_q <= cfg_data[8:0];
					REG_DRAW_PIXELS: cfg_draw_pixels_q <= cfg_data[0];
					REG_DRAW_BACKGROUND: cfg_draw_bg_q <= cfg_data[0];
					default: ;
				endcase
			end

			if (push) out_valid_q <= 1'b1;
			else if (pix_out.ready) out_valid_q <= 1'b0;

			case (state_q)
				ST_CLEAR: lvl_q <= (lvl_q == LAST_LEVEL) ? '0 : lvl_q + 1'b1;
				ST_LOAD: begin
					if (load_ok) begin
						loaded_q <= loaded_q + 1'b1;
						if (ld_lv_q != '0) nonzero_q <= nonzero_q + 1'b1;
					end
				end
				ST_FIN_CHK: div_cnt_q <= '0;
				ST_FIN_DIV: begin
					div_cnt_q <= (div_cnt_q == DIVC_W'(QUO_W - 1)) ? '0 : div_cnt_q + 1'b1;
				end
				ST_FIN_WR: begin
					if (lvl_q == LAST_LEVEL) begin
						lvl_q         <= '0;
						phase_drain_q <= 1'b1;
						pos_q         <= '0;
					end else begin
						lvl_q <= lvl_q + 1'b1;
					end
				end
				ST_DRN_RD: pos_q <= pos_inc[PIX_W-1:0];
				ST_OUT: begin
					if (push && res_q.last_pixel) begin
						phase_drain_q <= 1'b0;
						loaded_q      <= '0;
						nonzero_q     <= '0;
						pos_q         <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		total_q <= PIX_W'(PIX_W'(w_eff) * PIX_W'(h_eff));

		if (push) out_data_q <= res_q;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ld_lv_q <= in_lv;
					ld_ci_q <= in_ci;
					cdf_q   <= '0;
					// out-of-phase drain: black, flagged
					res_q   <= '{first_channel: '0, second_channel: '0, third_channel: '0,
						last_pixel: 1'b0, out_of_order: 1'b1};
				end
			end
			ST_FIN_ACC: cdf_q <= cdf_q + hist_rd_q;
			ST_FIN_CHK: begin
				if (fin_zero) fin_val_q <= '0;
				else if (fin_reuse) fin_val_q <= prev_q;
				else fin_val_q <= '0;
				rem_q <= {1'b0, nonzero_q - cdf_q};
			end
			// one restoring division step
			ST_FIN_DIV: begin
				rem_q     <= div_ge ? div_t - {1'b0, nonzero_q} : div_t;
				fin_val_q <= {fin_val_q[QUO_W-2:0], div_ge};
			end
			ST_FIN_WR: prev_q <= fin_val_q;
			ST_DRN_RD: begin
				res_q <= '{first_channel: '0, second_channel: '0, third_channel: '0,
					last_pixel: (pos_inc >= {1'b0, total_q}), out_of_order: 1'b0};
			end
			ST_DRN_LV: ci_q <= px_ci;
			ST_DRN_COL: begin
				res_q.first_channel  <= weigh(hist_rd_q[QUO_W-1:0], WEIGHT_TABLE[ci_q][0]);
				res_q.second_channel <= weigh(hist_rd_q[QUO_W-1:0], WEIGHT_TABLE[ci_q][1]);
				res_q.third_channel  <= weigh(hist_rd_q[QUO_W-1:0], WEIGHT_TABLE[ci_q][2]);
			end
			default: ;
		endcase
	end

	// Assertions
	a_idle_level_zero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> lvl_q == '0)
		else $error("level counter not parked at zero while idle");

	a_nonzero_le_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		nonzero_q <= loaded_q)
		else $error("nonzero count exceeds loaded count");

	a_loaded_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q <= PIX_W'(PIXELS))
		else $error("loaded count beyond pixel store");

	a_ooo_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.out_of_order |-> !out_data_q.last_pixel &&
		out_data_q.first_channel == '0 && out_data_q.second_channel == '0 &&
		out_data_q.third_channel == '0)
		else $error("out-of-order result carries pixel data");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		push && res_q.last_pixel |=> state_q == ST_CLEAR && !phase_drain_q)
		else $error("final drain did not start the clearing pass");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN_DIV |-> rem_q <= {1'b0, nonzero_q})
		else $error("divider remainder out of range");

endmodule

// ===== tb/dhc_checker.sv =====
// ----------------------------------------------------------------------------
// dhc_checker: prediction and comparison for the depth histogram colouriser
// Watches the configuration port and both channels, keeps its own copy of
// the frame store, histogram and frame phase, works out the colour of each
// drained pixel and compares every output transaction field by field.
// ----------------------------------------------------------------------------
module dhc_checker
	import dhc_pkg::*;
#(
	parameter int MAX_WIDTH    = 640,
	parameter int MAX_HEIGHT   = 480,
	parameter int DEPTH_LEVELS = 16384,
	parameter int COLOR_COUNT  = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  in_item_t               in_data,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  out_item_t              out_data,
	output int unsigned            pending,
	output int unsigned            errors
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned PIXELS    = MAX_WIDTH * MAX_HEIGHT;
	localparam int unsigned LEVEL_TOP = DEPTH_LEVELS - 1;
	localparam int          LEVEL_W   = $clog2(DEPTH_LEVELS);
	localparam logic [3:0]  WHITE_SLOT = 4'd10;

	typedef enum logic {PH_LOADING, PH_DRAINING} phase_t;
	typedef enum logic [1:0] {SH_OFF, SH_HALF, SH_FULL} shade_t;

	// Per colour slot, the weight of each channel; the last slot is white
	localparam shade_t PALETTE [11][3] = '{
		'{SH_OFF,  SH_FULL, SH_FULL},
		'{SH_OFF,  SH_OFF,  SH_FULL},
		'{SH_OFF,  SH_FULL, SH_OFF},
		'{SH_FULL, SH_FULL, SH_OFF},
		'{SH_FULL, SH_OFF,  SH_OFF},
		'{SH_FULL, SH_HALF, SH_OFF},
		'{SH_HALF, SH_FULL, SH_OFF},
		'{SH_OFF,  SH_HALF, SH_FULL},
		'{SH_HALF, SH_OFF,  SH_FULL},
		'{SH_FULL, SH_FULL, SH_HALF},
		'{SH_FULL, SH_FULL, SH_FULL}
	};

	// Shadow of the registers and the frame state
	logic [9:0]         width_reg;
	logic [8:0]         height_reg;
	logic               draw_px;
	logic               draw_bg;
	logic [LEVEL_W-1:0] level_mem [PIXELS];
	logic [3:0]         slot_mem [PIXELS];
	int unsigned        level_count [DEPTH_LEVELS];
	int unsigned        loaded;
	int unsigned        nonzero;
	int unsigned        drain_pos;
	phase_t             phase;
	out_item_t          colour_q [$];

	// Pixels in the frame, with zero sizes taken as one and large ones saturated
	function automatic int unsigned frame_pixels();
		int unsigned w;
		int unsigned h;
		w = (width_reg == 0) ? 1 : width_reg;
		h = (height_reg == 0) ? 1 : height_reg;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		if (h > MAX_HEIGHT) h = MAX_HEIGHT;
		return w * h;
	endfunction

	function automatic logic [7:0] shade(input int unsigned v, input shade_t s);
		case (s)
			SH_FULL: return 8'(v);
			SH_HALF: return 8'(v >> 1);
			default: return 8'd0;
		endcase
	endfunction

	function automatic void clear_levels();
		foreach (level_count[i]) level_count[i] = 0;
	endfunction

	// Histogram becomes brightness: floor(256 * (N - cdf) / N), level 0 black
	function automatic void equalise_levels();
		longint unsigned cdf;
		longint unsigned n;
		cdf = 0;
		n = nonzero;
		for (int unsigned lv = 0; lv < DEPTH_LEVELS; lv++) begin
			cdf += level_count[lv];
			if (lv == 0 || n == 0 || cdf > n)
				level_count[lv] = 0;
			else
				level_count[lv] = int'((256 * (n - cdf)) / n);
		end
	endfunction

	// One accepted command: update the shadow state, queue any colour due
	function automatic void take_command(input in_item_t it);
		int unsigned total;
		int unsigned lv;
		int unsigned bright;
		logic [3:0]  slot;
		out_item_t   res;
		total = frame_pixels();
		res = '0;
		case (it.cmd)
			CMD_LOAD: begin
				if (phase == PH_LOADING && loaded < total) begin
					lv = (it.depth > LEVEL_TOP) ? LEVEL_TOP : it.depth;
					level_mem[loaded] = LEVEL_W'(lv);
					slot_mem[loaded] = (it.label == 0) ? WHITE_SLOT
						: 4'(it.label % COLOR_COUNT);
					if (lv != 0) begin
						level_count[lv]++;
						nonzero++;
					end
					loaded++;
				end
			end
			CMD_FINISH: begin
				if (phase == PH_LOADING) begin
					equalise_levels();
					drain_pos = 0;
					phase = PH_DRAINING;
				end
			end
			CMD_DRAIN: begin
				if (phase != PH_DRAINING) begin
					res.out_of_order = 1'b1;
				end else begin
					// unloaded positions of a short frame stay black
					if (draw_px && drain_pos < loaded) begin
						lv = level_mem[drain_pos];
						slot = slot_mem[drain_pos];
						if ((draw_bg || slot != WHITE_SLOT) && lv != 0) begin
							bright = level_count[lv];
							res.first_channel  = shade(bright, PALETTE[slot][0]);
							res.second_channel = shade(bright, PALETTE[slot][1]);
							res.third_channel  = shade(bright, PALETTE[slot][2]);
						end
					end
					drain_pos++;
					// also catches a frame shrunk below the drain position
					if (drain_pos >= total) begin
						res.last_pixel = 1'b1;
						clear_levels();
						loaded = 0;
						nonzero = 0;
						drain_pos = 0;
						phase = PH_LOADING;
					end
				end
				colour_q = {colour_q, res};
			end
			default: ;
		endcase
	endfunction

	function automatic int unsigned field_differs(input string name,
			input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	// Compare before predicting, so a result never meets its own command
	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t   want;
		int unsigned err_now;
		err_now = 0;
		if (!arst_n) begin
			width_reg = 10'd640;
			height_reg = 9'd480;
			draw_px = 1'b1;
			draw_bg = 1'b1;
			clear_levels();
			loaded = 0;
			nonzero = 0;
			drain_pos = 0;
			phase = PH_LOADING;
			colour_q.delete();
			pending <= 0;
			errors <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (colour_q.size() == 0) begin
					$error("output transaction with no drain outstanding");
					err_now++;
				end else begin
					want = colour_q.pop_front();
					err_now += field_differs("first_channel", want.first_channel,
						out_data.first_channel);
					err_now += field_differs("second_channel", want.second_channel,
						out_data.second_channel);
					err_now += field_differs("third_channel", want.third_channel,
						out_data.third_channel);
					err_now += field_differs("last_pixel", 8'(want.last_pixel),
						8'(out_data.last_pixel));
					err_now += field_differs("out_of_order", 8'(want.out_of_order),
						8'(out_data.out_of_order));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_FRAME_WIDTH:     width_reg = cfg_data[9:0];
					REG_FRAME_HEIGHT:    height_reg = cfg_data[8:0];
					REG_DRAW_PIXELS:     draw_px = cfg_data[0];
					REG_DRAW_BACKGROUND: draw_bg = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				take_command(in_data);
			pending <= colour_q.size();
			errors <= errors + err_now;
		end
	end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the depth histogram colouriser
// Resets the block, runs a short directed set of frames covering the size
// extremes, clamping, ignored commands and out-of-phase drains, then random
// frames of varied size and draw mode with random gaps on the command side
// and random stalls on the colour side. The checker does all comparison.
// ----------------------------------------------------------------------------
module tb;
	import dhc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_WIDTH    = 640;
	localparam int MAX_HEIGHT   = 480;
	localparam int DEPTH_LEVELS = 16384;
	localparam int COLOR_COUNT  = 10;

	localparam int unsigned ITEM_TARGET = 800;
	localparam int unsigned CYCLE_LIMIT = 8_000_000;
	localparam int unsigned TAIL_CYCLES = 64;
	localparam logic [1:0]  CMD_NONE    = 2'd3;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	int unsigned            pending;
	int unsigned            errors;
	int unsigned            cycles = 0;
	int unsigned            hold = 0;
	logic                   steady_out = 1'b0;
	logic                   bursty = 1'b0;
	int unsigned            taken = 0;

	dhc_stream_if #(.data_t(in_item_t))  pix_in_ch ();
	dhc_stream_if #(.data_t(out_item_t)) pix_out_ch ();

	depth_histogram_colorizer #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_HEIGHT   (MAX_HEIGHT),
		.DEPTH_LEVELS (DEPTH_LEVELS),
		.COLOR_COUNT  (COLOR_COUNT)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_in    (pix_in_ch),
		.pix_out   (pix_out_ch)
	);

	dhc_checker #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_HEIGHT   (MAX_HEIGHT),
		.DEPTH_LEVELS (DEPTH_LEVELS),
		.COLOR_COUNT  (COLOR_COUNT)
	) u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (pix_in_ch.valid),
		.in_ready  (pix_in_ch.ready),
		.in_data   (pix_in_ch.data),
		.out_valid (pix_out_ch.valid),
		.out_ready (pix_out_ch.ready),
		.out_data  (pix_out_ch.data),
		.pending   (pending),
		.errors    (errors)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Colour side: stretches of steady acceptance and stretches of stalls
	always @(posedge clk) begin : out_stall
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (!arst_n) begin
			pix_out_ch.ready <= 1'b0;
		end else if (hold != 0) begin
			hold <= hold - 1;
		end else if (steady_out) begin
			pix_out_ch.ready <= 1'b1;
			hold <= $urandom_range(0, 30);
			if (roll < 4) steady_out <= 1'b0;
		end else begin
			if (roll < 60) begin
				pix_out_ch.ready <= 1'b1;
				hold <= $urandom_range(0, 3);
			end else if (roll < 92) begin
				pix_out_ch.ready <= 1'b0;
				hold <= $urandom_range(0, 3);
			end else begin
				pix_out_ch.ready <= 1'b0;
				hold <= $urandom_range(10, 40);
			end
			if (roll == 0 || roll == 61) steady_out <= 1'b1;
		end
	end

	// Gap before a command: mostly none, some short, a few long
	function automatic int unsigned idle_len();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (bursty || roll < 60) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Zero, above the level range, a few repeated levels, or anywhere
	function automatic logic [15:0] pick_depth();
		int unsigned roll;
		roll = $urandom_range(0, 15);
		if (roll < 2) return 16'd0;
		if (roll < 4) return 16'($urandom_range(DEPTH_LEVELS, 65535));
		if (roll < 8) return 16'($urandom_range(1, 12));
		return 16'($urandom_range(1, DEPTH_LEVELS - 1));
	endfunction

	function automatic logic [7:0] pick_label();
		if ($urandom_range(0, 3) == 0) return 8'd0;
		return 8'($urandom);
	endfunction

	// One command transaction; valid stays high into the next when there is no gap
	task automatic issue(input logic [1:0] c, input logic [15:0] d, input logic [7:0] l);
		int unsigned gap;
		gap = idle_len();
		if (gap != 0) begin
			pix_in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_in_ch.valid <= 1'b1;
		pix_in_ch.data <= '{cmd: c, depth: d, label: l};
		do @(posedge clk); while (!pix_in_ch.ready);
	endtask

	// Hold off until every colour has come back and the block takes commands
	task automatic settle();
		pix_in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0 || !pix_in_ch.ready);
		repeat (2) @(posedge clk);
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
			input logic [CFG_DATA_W-1:0] px, input logic [CFG_DATA_W-1:0] bg);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= REG_FRAME_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		cfg_index <= REG_DRAW_PIXELS;
		cfg_data <= px;
		@(posedge clk);
		cfg_index <= REG_DRAW_BACKGROUND;
		cfg_data <= bg;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		int unsigned w;
		int unsigned h;
		int unsigned span;
		int unsigned loads;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		pix_in_ch.valid <= 1'b0;
		pix_in_ch.data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Drain while still loading, and an unknown command
		settle();
		issue(CMD_DRAIN, 16'hFFFF, 8'hFF);
		issue(CMD_NONE, 16'hFFFF, 8'hFF);

		// Four-pixel frame, zero width taken as one; one load past the end
		configure(10'd0, 10'd4, 10'd1, 10'd1);
		issue(CMD_LOAD, 16'd0, 8'd5);
		issue(CMD_LOAD, 16'hFFFF, 8'd0);
		issue(CMD_LOAD, 16'd1, 8'd255);
		issue(CMD_LOAD, 16'(DEPTH_LEVELS - 1), 8'd9);
		issue(CMD_LOAD, 16'd100, 8'd3);
		issue(CMD_FINISH, 16'd0, 8'd0);
		// ignored while draining
		issue(CMD_LOAD, 16'd5, 8'd1);
		issue(CMD_FINISH, 16'd0, 8'd0);
		issue(CMD_NONE, 16'h0000, 8'h00);
		repeat (4) issue(CMD_DRAIN, 16'd0, 8'd0);
		// frame over, so this one is out of phase
		issue(CMD_DRAIN, 16'd0, 8'd0);

		// Saturated sizes, background hidden, a short frame then shrunk mid-drain
		configure(10'h3FF, 10'h3FF, 10'd1, 10'h3FE);
		issue(CMD_LOAD, 16'd2, 8'd0);
		issue(CMD_LOAD, 16'd7, 8'd4);
		issue(CMD_FINISH, 16'd0, 8'd0);
		repeat (2) issue(CMD_DRAIN, 16'd0, 8'd0);
		configure(10'd1, 10'd1, 10'd1, 10'd0);
		issue(CMD_DRAIN, 16'd0, 8'd0);

		// Random frames: mostly well-formed, with noise and broken ones
		while (taken < ITEM_TARGET) begin
			w = $urandom_range(0, 16);
			h = $urandom_range(0, 8);
			configure(CFG_DATA_W'(w), CFG_DATA_W'(h),
				{9'($urandom), $urandom_range(0, 4) != 0},
				{9'($urandom), 1'($urandom_range(0, 1))});
			bursty = ($urandom_range(0, 3) == 0);
			span = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
			case ($urandom_range(0, 9))
				0: loads = $urandom_range(0, span - 1);
				1: loads = span + $urandom_range(1, 4);
				default: loads = span;
			endcase
			for (int unsigned n = 0; n < loads; n++) begin
				if ($urandom_range(0, 15) == 0)
					issue($urandom_range(0, 1) ? CMD_DRAIN : CMD_NONE,
						16'($urandom), 8'($urandom));
				issue(CMD_LOAD, pick_depth(), pick_label());
			end
			taken += ((loads < span) ? loads : span) + 1;
			issue(CMD_FINISH, 16'($urandom), 8'($urandom));
			for (int unsigned n = 0; n < span; n++) begin
				case ($urandom_range(0, 39))
					0: settle();
					1: issue(CMD_LOAD, pick_depth(), pick_label());
					2: issue(CMD_FINISH, 16'($urandom), 8'($urandom));
					3: issue(CMD_NONE, 16'($urandom), 8'($urandom));
					default: ;
				endcase
				issue(CMD_DRAIN, 16'($urandom), 8'($urandom));
			end
			taken += span;
			if ($urandom_range(0, 3) == 0) begin
				issue(CMD_DRAIN, 16'($urandom), 8'($urandom));
				taken++;
			end
		end

		// Drain everything, then watch for stray output transactions
		pix_in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
